// ----- sv/lavr_pkg.sv -----
// Shared types and constants for the look-at view rotation pipeline.
// No dependencies; used by lavr_norm and look_at_view_rotation_top.
package lavr_pkg;

   localparam int NORM_LAT  = 71;
   localparam int CROSS_LAT = 2;
   localparam int S_LINE    = NORM_LAT + CROSS_LAT;
   localparam int F_LINE    = 2 * S_LINE;
   localparam int PIPE_LAT  = 3 * NORM_LAT + 2 * CROSS_LAT + 2;

   localparam logic [31:0] UP_X_RESET = 32'h0000_0000;
   localparam logic [31:0] UP_Y_RESET = 32'h0001_0000;
   localparam logic [31:0] UP_Z_RESET = 32'h0000_0000;

   typedef enum logic [1:0] {
      REG_UP_X = 2'd0,
      REG_UP_Y = 2'd1,
      REG_UP_Z = 2'd2
   } reg_idx_type;

   typedef logic [2:0][63:0] wide_vec_type;
   typedef logic [2:0][31:0] unit_vec_type;
   typedef logic [2:0][30:0] mant_vec_type;

   typedef struct packed {
      mant_vec_type c;
      logic [2:0]   neg;
      logic         zero;
   } nrm_side_type;

   typedef struct packed {
      logic [31:0] eye_x;
      logic [31:0] eye_y;
      logic [31:0] eye_z;
      logic [31:0] target_x;
      logic [31:0] target_y;
      logic [31:0] target_z;
   } req_data_type;

   typedef struct packed {
      logic [31:0] side_x;
      logic [31:0] side_y;
      logic [31:0] side_z;
      logic [31:0] true_up_x;
      logic [31:0] true_up_y;
      logic [31:0] true_up_z;
      logic [31:0] back_x;
      logic [31:0] back_y;
      logic [31:0] back_z;
      logic        degenerate;
   } rsp_data_type;

endpackage

// ----- sv/look_at_view_rotation_top.sv -----
// Throughput one transaction per cycle, unless a stalled result holds the pipeline.
// Three 71-stage normalizers in a row set the latency, each a bit-per-stage square root
// followed by a bit-per-stage divider; the cross products add two stages each.
// A stalled result freezes the whole pipeline; nothing is dropped.
// Reset (synchronous) clears all valid bits and sets the up vector to (0, 1, 0).
// Depends on lavr_pkg and lavr_norm.
module look_at_view_rotation_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lavr_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lavr_pkg::rsp_data_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [3:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic                   adv;
   logic                   vld_ff [0:lavr_pkg::PIPE_LAT-1];
   logic [2:0][31:0]       up_ff;
   logic [2:0][31:0]       eye, tgt;
   logic signed [32:0]     dif;
   lavr_pkg::wide_vec_type d_ff, d_in;
   lavr_pkg::unit_vec_type f_vec, s_vec, u_vec;
   logic                   f_zero, s_zero, u_zero;
   logic [5:0][63:0]       xa_ff, xa_in, xb_ff, xb_in;
   lavr_pkg::wide_vec_type xa2_ff, xa2_in, xb2_ff, xb2_in;
   lavr_pkg::unit_vec_type fd_ff [0:lavr_pkg::F_LINE-1];
   logic                   fz_ff [0:lavr_pkg::F_LINE-1];
   lavr_pkg::unit_vec_type sd_ff [0:lavr_pkg::S_LINE-1];
   logic                   sz_ff [0:lavr_pkg::S_LINE-1];
   lavr_pkg::unit_vec_type f_tap;
   lavr_pkg::rsp_data_type rsp_ff, rsp_in;
   logic                   degen;

   assign adv       = !vld_ff[lavr_pkg::PIPE_LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[lavr_pkg::PIPE_LAT-1];
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff[0] <= lavr_pkg::UP_X_RESET;
         up_ff[1] <= lavr_pkg::UP_Y_RESET;
         up_ff[2] <= lavr_pkg::UP_Z_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            lavr_pkg::REG_UP_X: up_ff[0] <= pwdata;
            lavr_pkg::REG_UP_Y: up_ff[1] <= pwdata;
            lavr_pkg::REG_UP_Z: up_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         lavr_pkg::REG_UP_X: prdata = up_ff[0];
         lavr_pkg::REG_UP_Y: prdata = up_ff[1];
         lavr_pkg::REG_UP_Z: prdata = up_ff[2];
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < lavr_pkg::PIPE_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < lavr_pkg::PIPE_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // eye - target, sign extended
   always_comb begin
      eye = {req_data.eye_z, req_data.eye_y, req_data.eye_x};
      tgt = {req_data.target_z, req_data.target_y, req_data.target_x};
      dif = '0;
      for (int i = 0; i < 3; i++) begin
         dif     = $signed({eye[i][31], eye[i]}) - $signed({tgt[i][31], tgt[i]});
         d_in[i] = {{31{dif[32]}}, dif};
      end
   end

   lavr_norm u_norm_back (
      .clock    (clock),
      .en       (adv),
      .vec_in   (d_ff),
      .unit_out (f_vec),
      .zero_out (f_zero)
   );

   // cross(back, up): products, then differences
   always_comb begin
      logic signed [63:0] pr;
      pr = '0;
      pr = $signed(f_vec[1]) * $signed(up_ff[2]); xa_in[0] = pr;
      pr = $signed(f_vec[2]) * $signed(up_ff[1]); xa_in[1] = pr;
      pr = $signed(f_vec[2]) * $signed(up_ff[0]); xa_in[2] = pr;
      pr = $signed(f_vec[0]) * $signed(up_ff[2]); xa_in[3] = pr;
      pr = $signed(f_vec[0]) * $signed(up_ff[1]); xa_in[4] = pr;
      pr = $signed(f_vec[1]) * $signed(up_ff[0]); xa_in[5] = pr;
      for (int k = 0; k < 3; k++) begin
         xa2_in[k] = xa_ff[2*k] - xa_ff[2*k+1];
      end
   end

   lavr_norm u_norm_side (
      .clock    (clock),
      .en       (adv),
      .vec_in   (xa2_ff),
      .unit_out (s_vec),
      .zero_out (s_zero)
   );

   assign f_tap = fd_ff[lavr_pkg::S_LINE-1];

   // cross(side, back) with back taken from the delay line
   always_comb begin
      logic signed [63:0] pr;
      pr = '0;
      pr = $signed(s_vec[1]) * $signed(f_tap[2]); xb_in[0] = pr;
      pr = $signed(s_vec[2]) * $signed(f_tap[1]); xb_in[1] = pr;
      pr = $signed(s_vec[2]) * $signed(f_tap[0]); xb_in[2] = pr;
      pr = $signed(s_vec[0]) * $signed(f_tap[2]); xb_in[3] = pr;
      pr = $signed(s_vec[0]) * $signed(f_tap[1]); xb_in[4] = pr;
      pr = $signed(s_vec[1]) * $signed(f_tap[0]); xb_in[5] = pr;
      for (int k = 0; k < 3; k++) begin
         xb2_in[k] = xb_ff[2*k] - xb_ff[2*k+1];
      end
   end

   lavr_norm u_norm_up (
      .clock    (clock),
      .en       (adv),
      .vec_in   (xb2_ff),
      .unit_out (u_vec),
      .zero_out (u_zero)
   );

   // zero every vector field when any normalization saw a zero vector
   always_comb begin
      lavr_pkg::unit_vec_type fo, so, uo;
      degen = fz_ff[lavr_pkg::F_LINE-1] || sz_ff[lavr_pkg::S_LINE-1] || u_zero;
      fo    = degen ? '0 : fd_ff[lavr_pkg::F_LINE-1];
      so    = degen ? '0 : sd_ff[lavr_pkg::S_LINE-1];
      uo    = degen ? '0 : u_vec;
      rsp_in.side_x     = so[0];
      rsp_in.side_y     = so[1];
      rsp_in.side_z     = so[2];
      rsp_in.true_up_x  = uo[0];
      rsp_in.true_up_y  = uo[1];
      rsp_in.true_up_z  = uo[2];
      rsp_in.back_x     = fo[0];
      rsp_in.back_y     = fo[1];
      rsp_in.back_z     = fo[2];
      rsp_in.degenerate = degen;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff   <= d_in;
         xa_ff  <= xa_in;
         xa2_ff <= xa2_in;
         xb_ff  <= xb_in;
         xb2_ff <= xb2_in;
         fd_ff[0] <= f_vec;
         fz_ff[0] <= f_zero;
         for (int k = 1; k < lavr_pkg::F_LINE; k++) begin
            fd_ff[k] <= fd_ff[k-1];
            fz_ff[k] <= fz_ff[k-1];
         end
         sd_ff[0] <= s_vec;
         sz_ff[0] <= s_zero;
         for (int k = 1; k < lavr_pkg::S_LINE; k++) begin
            sd_ff[k] <= sd_ff[k-1];
            sz_ff[k] <= sz_ff[k-1];
         end
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- sv/lavr_norm.sv -----
// Pipelined 3-vector normalizer: signed 64-bit components in, Q1.30 unit vector out.
// Depends on lavr_pkg; one bit of square root and one quotient bit per stage.
module lavr_norm (
   input  logic                   clock,
   input  logic                   en,
   input  lavr_pkg::wide_vec_type vec_in,
   output lavr_pkg::unit_vec_type unit_out,
   output logic                   zero_out
);

   // magnitude stage
   logic [2:0]             neg1_ff, neg1_in;
   lavr_pkg::wide_vec_type mag1_ff, mag1_in;
   // chunk leading-one stage
   logic [2:0]             neg2_ff;
   lavr_pkg::wide_vec_type mag2_ff;
   logic [3:0]             cnz2_ff, cnz2_in;
   logic [3:0][3:0]        cpos2_ff, cpos2_in;
   logic [63:0]            orw;
   // leading-one position
   logic [5:0]             p3_ff, p3_in;
   logic                   zero3_ff, zero3_in;
   lavr_pkg::wide_vec_type mag3_ff;
   logic [2:0]             neg3_ff;
   // scaled magnitudes
   lavr_pkg::mant_vec_type c4_ff, c4_in;
   logic [2:0]             neg4_ff;
   logic                   zero4_ff;
   logic [5:0]             sh;
   logic [63:0]            sht;
   // squares
   logic [2:0][61:0]       sq5_ff, sq5_in;
   lavr_pkg::nrm_side_type side5_ff;
   // square root
   logic [63:0]            sr_rad_ff  [0:32];
   logic [63:0]            sr_rad_in  [0:32];
   logic [34:0]            sr_rem_ff  [0:32];
   logic [34:0]            sr_rem_in  [0:32];
   logic [31:0]            sr_root_ff [0:32];
   logic [31:0]            sr_root_in [0:32];
   lavr_pkg::nrm_side_type sr_side_ff [0:32];
   // division
   logic [2:0][31:0]       dv_rem_ff  [0:31];
   logic [2:0][31:0]       dv_rem_in  [0:31];
   lavr_pkg::mant_vec_type dv_low_ff  [0:31];
   lavr_pkg::mant_vec_type dv_low_in  [0:31];
   lavr_pkg::mant_vec_type dv_q_ff    [0:31];
   lavr_pkg::mant_vec_type dv_q_in    [0:31];
   logic [31:0]            dv_len_ff  [0:31];
   logic [2:0]             dv_neg_ff  [0:31];
   logic                   dv_zero_ff [0:31];
   // result
   lavr_pkg::unit_vec_type unit_ff, unit_in;
   logic                   zero_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = vec_in[i][63];
         mag1_in[i] = vec_in[i][63] ? (~vec_in[i] + 64'd1) : vec_in[i];
      end
   end

   always_comb begin
      orw = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      for (int ch = 0; ch < 4; ch++) begin
         cnz2_in[ch]  = |orw[ch*16 +: 16];
         cpos2_in[ch] = 4'd0;
         for (int b = 0; b < 16; b++) begin
            if (orw[ch*16 + b]) begin
               cpos2_in[ch] = 4'(b);
            end
         end
      end
   end

   always_comb begin
      p3_in    = 6'd0;
      zero3_in = 1'b1;
      for (int ch = 0; ch < 4; ch++) begin
         if (cnz2_ff[ch]) begin
            p3_in    = {2'(ch), cpos2_ff[ch]};
            zero3_in = 1'b0;
         end
      end
   end

   // bring the largest magnitude into [2^30, 2^31)
   always_comb begin
      sh  = (p3_ff >= 6'd30) ? (p3_ff - 6'd30) : (6'd30 - p3_ff);
      sht = 64'd0;
      for (int i = 0; i < 3; i++) begin
         sht      = (p3_ff >= 6'd30) ? (mag3_ff[i] >> sh) : (mag3_ff[i] << sh);
         c4_in[i] = sht[30:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq5_in[i] = 62'(c4_ff[i]) * 62'(c4_ff[i]);
      end
   end

   always_comb begin
      logic [34:0] t;
      logic [34:0] trial;
      t     = '0;
      trial = '0;
      sr_rad_in[0]  = 64'(sq5_ff[0]) + 64'(sq5_ff[1]) + 64'(sq5_ff[2]);
      sr_rem_in[0]  = '0;
      sr_root_in[0] = '0;
      for (int k = 0; k < 32; k++) begin
         t     = {sr_rem_ff[k][32:0], sr_rad_ff[k][63:62]};
         trial = {1'b0, sr_root_ff[k], 2'b01};
         if (t >= trial) begin
            sr_rem_in[k+1]  = t - trial;
            sr_root_in[k+1] = {sr_root_ff[k][30:0], 1'b1};
         end else begin
            sr_rem_in[k+1]  = t;
            sr_root_in[k+1] = {sr_root_ff[k][30:0], 1'b0};
         end
         sr_rad_in[k+1] = {sr_rad_ff[k][61:0], 2'b00};
      end
   end

   // numerator c*2^30 + L/2, first 31 bits seed the remainder
   always_comb begin
      logic [61:0] n;
      logic [32:0] t;
      logic [32:0] t_sub;
      n     = '0;
      t     = '0;
      t_sub = '0;
      for (int i = 0; i < 3; i++) begin
         n = {1'b0, sr_side_ff[32].c[i], 30'd0} + {31'd0, sr_root_ff[32][31:1]};
         dv_rem_in[0][i] = {1'b0, n[61:31]};
         dv_low_in[0][i] = n[30:0];
         dv_q_in[0][i]   = '0;
      end
      for (int j = 0; j < 31; j++) begin
         for (int i = 0; i < 3; i++) begin
            t     = {dv_rem_ff[j][i], dv_low_ff[j][i][30]};
            t_sub = t - {1'b0, dv_len_ff[j]};
            if (t >= {1'b0, dv_len_ff[j]}) begin
               dv_rem_in[j+1][i] = t_sub[31:0];
               dv_q_in[j+1][i]   = {dv_q_ff[j][i][29:0], 1'b1};
            end else begin
               dv_rem_in[j+1][i] = t[31:0];
               dv_q_in[j+1][i]   = {dv_q_ff[j][i][29:0], 1'b0};
            end
            dv_low_in[j+1][i] = {dv_low_ff[j][i][29:0], 1'b0};
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unit_in[i] = dv_neg_ff[31][i] ? (32'd0 - {1'b0, dv_q_ff[31][i]})
                                       : {1'b0, dv_q_ff[31][i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff  <= neg1_in;
         mag1_ff  <= mag1_in;
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         cnz2_ff  <= cnz2_in;
         cpos2_ff <= cpos2_in;
         p3_ff    <= p3_in;
         zero3_ff <= zero3_in;
         mag3_ff  <= mag2_ff;
         neg3_ff  <= neg2_ff;
         c4_ff    <= c4_in;
         neg4_ff  <= neg3_ff;
         zero4_ff <= zero3_ff;
         sq5_ff   <= sq5_in;
         side5_ff <= '{c: c4_ff, neg: neg4_ff, zero: zero4_ff};
         sr_side_ff[0] <= side5_ff;
         for (int k = 0; k <= 32; k++) begin
            sr_rad_ff[k]  <= sr_rad_in[k];
            sr_rem_ff[k]  <= sr_rem_in[k];
            sr_root_ff[k] <= sr_root_in[k];
         end
         for (int k = 1; k <= 32; k++) begin
            sr_side_ff[k] <= sr_side_ff[k-1];
         end
         dv_len_ff[0]  <= sr_root_ff[32];
         dv_neg_ff[0]  <= sr_side_ff[32].neg;
         dv_zero_ff[0] <= sr_side_ff[32].zero;
         for (int j = 0; j <= 31; j++) begin
            dv_rem_ff[j] <= dv_rem_in[j];
            dv_low_ff[j] <= dv_low_in[j];
            dv_q_ff[j]   <= dv_q_in[j];
         end
         for (int j = 1; j <= 31; j++) begin
            dv_len_ff[j]  <= dv_len_ff[j-1];
            dv_neg_ff[j]  <= dv_neg_ff[j-1];
            dv_zero_ff[j] <= dv_zero_ff[j-1];
         end
         unit_ff <= unit_in;
         zero_ff <= dv_zero_ff[31];
      end
   end

   assign unit_out = unit_ff;
   assign zero_out = zero_ff;

endmodule
